### hw/rtl/bam_pkg.sv
// bam_pkg: shared types, codes and constants of the bitmap allocation map
// used by bam_ctrl, bam_datapath and bitmap_allocation_map; no dependencies
package bam_pkg;

  localparam int MAP_BITS_DEF  = 1024;
  localparam int WORD_BITS_DEF = 64;
  localparam int MAX_RUN       = 64;
  localparam int CFG_W         = 11;
  localparam int OP_W          = 3;
  localparam int IDX_W         = 10;
  localparam int LEN_W         = 7;
  localparam int STATUS_W      = 2;

  typedef enum logic [OP_W-1:0] {
    OP_SET        = 3'd0,
    OP_CLEAR      = 3'd1,
    OP_READ       = 3'd2,
    OP_FIND_CLEAR = 3'd3,
    OP_FIND_RUN   = 3'd4
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK    = 2'd0,
    STS_NONE  = 2'd1,
    STS_RANGE = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    KIND_BAD,
    KIND_BIT,
    KIND_SCAN
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACCESS,
    ST_MODIFY,
    ST_SCAN,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [OP_W-1:0]  operation;
    logic [IDX_W-1:0] bit_index;
    logic [LEN_W-1:0] run_length;
  } in_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                bit_value;
    logic [IDX_W-1:0]    position;
  } out_t;

  typedef struct packed {
    logic start;
    logic rd_bit;
    logic modify;
    logic scan;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    kind_e kind;
    logic  scan_end;
  } sts_t;

endpackage

### hw/rtl/bitmap_allocation_map.sv
// bitmap_allocation_map: first-fit bit map allocator, one result beat per request beat
// set, clear and read pass through the access and modify states, bad requests go to done;
// searches read one memory word per cycle through the single read port until a fit or
// the last word in use; one request in flight, next accepted once its result is loaded
// into the output register; reset clears the map through per-word valid flags at once;
// size resets to MAP_BITS capped at 2**CFG_W-1; depends on bam_pkg, bam_ctrl, bam_datapath
module bitmap_allocation_map #(
  parameter int MAP_BITS  = bam_pkg::MAP_BITS_DEF,
  parameter int WORD_BITS = bam_pkg::WORD_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [bam_pkg::CFG_W-1:0] cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  bam_pkg::in_t              in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output bam_pkg::out_t             out_data_o
);

  bam_pkg::cmd_t cmd;
  bam_pkg::sts_t sts;

  bam_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  bam_datapath #(
    .MAP_BITS  (MAP_BITS),
    .WORD_BITS (WORD_BITS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (out_data_o)
  );

  // an accepted beat closes the input until its result is loaded
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not closed after accept");

  // result register never overwritten while a beat waits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> (!out_valid_o || !out_stall_i))
    else $error("result overwritten while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.start, cmd.rd_bit, cmd.modify, cmd.scan, cmd.out_load}))
    else $error("conflicting commands");

  // only a found search reports a position
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status != bam_pkg::STS_OK) |-> (out_data_o.position == '0))
    else $error("position set on failed request");

endmodule

### hw/rtl/bam_ctrl.sv
// bam_ctrl: sequencer of the bitmap allocation map and output valid flag
// depends on bam_pkg; drives commands to bam_datapath
module bam_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  input  bam_pkg::sts_t   sts_i,
  output bam_pkg::cmd_t   cmd_o
);

  bam_pkg::state_e state_q, state_d;
  logic            out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bam_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      bam_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          unique case (sts_i.kind)
            bam_pkg::KIND_BIT:  state_d = bam_pkg::ST_ACCESS;
            bam_pkg::KIND_SCAN: state_d = bam_pkg::ST_SCAN;
            default:            state_d = bam_pkg::ST_DONE;
          endcase
        end
      end
      bam_pkg::ST_ACCESS: begin
        cmd_o.rd_bit = 1'b1;
        state_d      = bam_pkg::ST_MODIFY;
      end
      bam_pkg::ST_MODIFY: begin
        cmd_o.modify = 1'b1;
        state_d      = bam_pkg::ST_DONE;
      end
      bam_pkg::ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_end) begin
          state_d = bam_pkg::ST_DONE;
        end
      end
      bam_pkg::ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = bam_pkg::ST_IDLE;
        end
      end
      default: state_d = bam_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign in_stall_o  = (state_q != bam_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

### hw/rtl/bam_datapath.sv
// bam_datapath: word memory, size register, request decode, bit update and
// word-serial first-fit search with run carry; depends on bam_pkg
module bam_datapath #(
  parameter int MAP_BITS  = bam_pkg::MAP_BITS_DEF,
  parameter int WORD_BITS = bam_pkg::WORD_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [bam_pkg::CFG_W-1:0] cfg_data_i,
  input  bam_pkg::in_t              in_data_i,
  input  bam_pkg::cmd_t             cmd_i,
  output bam_pkg::sts_t             sts_o,
  output bam_pkg::out_t             out_data_o
);

  localparam int WC     = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int AW     = (WC > 1) ? $clog2(WC) : 1;
  localparam int CW     = $clog2(WC + 1);
  localparam int OW     = $clog2(WORD_BITS);
  localparam int SPAN_W = $clog2(WC * WORD_BITS + 1);
  localparam int XW     = ((SPAN_W > bam_pkg::CFG_W) ? SPAN_W : bam_pkg::CFG_W) + 1;
  localparam int SH     = bam_pkg::IDX_W + $clog2(WORD_BITS);
  localparam int RW     = SH + 1;
  localparam logic [RW-1:0] RECIP = RW'(((2 ** SH) + WORD_BITS - 1) / WORD_BITS);
  localparam int PW     = bam_pkg::IDX_W + RW;
  localparam int CFG_RST = (MAP_BITS > (2 ** bam_pkg::CFG_W) - 1) ?
                           (2 ** bam_pkg::CFG_W) - 1 : MAP_BITS;
  localparam logic [WORD_BITS-1:0] ONES = '1;

  logic [WORD_BITS-1:0]             mem [WC];
  logic [WC-1:0]                    vld_q;
  logic [WORD_BITS-1:0]             rd_word_q;
  logic                             rd_vld_q;
  logic [bam_pkg::CFG_W-1:0]        bits_in_use_q;
  logic [CW-1:0]                    rd_cnt_q;
  logic                             eval_valid_q;
  logic [bam_pkg::OP_W-1:0]         op_q;
  logic [bam_pkg::IDX_W-1:0]        idx_q;
  logic [bam_pkg::LEN_W-1:0]        len_q;
  logic [bam_pkg::IDX_W-1:0]        q_q;
  logic [XW-1:0]                    base_q;
  logic [bam_pkg::LEN_W-1:0]        carry_q, carry_d;
  bam_pkg::out_t                    res_q, out_q;

  logic [XW-1:0]                    size, cfg_ext;
  logic [PW-1:0]                    prod;
  logic [bam_pkg::IDX_W-1:0]        q_calc;
  logic [bam_pkg::IDX_W-1:0]        off_full;
  logic [OW-1:0]                    off;
  logic [WORD_BITS-1:0]             word, fw, bit_mask, new_word;
  logic [WORD_BITS-1:0]             hit;
  logic                             any_hit, last, rd_go, rd_en, wr_en;
  logic [AW-1:0]                    rd_addr, wr_addr;
  logic [OW-1:0]                    pick, hi;
  logic [XW-1:0]                    pos_full;

  // size in use and request decode
  assign cfg_ext = XW'(bits_in_use_q);
  assign size    = (cfg_ext > XW'(MAP_BITS)) ? XW'(MAP_BITS) : cfg_ext;

  always_comb begin
    sts_o.scan_end = eval_valid_q && (any_hit || last);
    unique case (in_data_i.operation)
      bam_pkg::OP_SET, bam_pkg::OP_CLEAR, bam_pkg::OP_READ: begin
        sts_o.kind = (XW'(in_data_i.bit_index) < size) ? bam_pkg::KIND_BIT
                                                       : bam_pkg::KIND_BAD;
      end
      bam_pkg::OP_FIND_CLEAR: sts_o.kind = bam_pkg::KIND_SCAN;
      bam_pkg::OP_FIND_RUN: begin
        sts_o.kind = (in_data_i.run_length != '0 &&
                      in_data_i.run_length <= bam_pkg::LEN_W'(bam_pkg::MAX_RUN))
                     ? bam_pkg::KIND_SCAN : bam_pkg::KIND_BAD;
      end
      default: sts_o.kind = bam_pkg::KIND_BAD;
    endcase
  end

  // word address and offset by reciprocal multiply
  assign prod     = PW'(idx_q) * PW'(RECIP);
  assign q_calc   = bam_pkg::IDX_W'(prod >> SH);
  assign off_full = idx_q - bam_pkg::IDX_W'(q_q * bam_pkg::IDX_W'(WORD_BITS));
  assign off      = OW'(off_full);

  assign word     = rd_vld_q ? rd_word_q : '0;
  assign bit_mask = WORD_BITS'(1) << off;
  assign new_word = (op_q == bam_pkg::OP_SET) ? (word | bit_mask) : (word & ~bit_mask);

  // memory control
  assign rd_go   = (rd_cnt_q < CW'(WC));
  assign rd_en   = cmd_i.rd_bit || (cmd_i.scan && rd_go);
  assign rd_addr = cmd_i.rd_bit ? AW'(q_calc) : rd_cnt_q[AW-1:0];
  assign wr_en   = cmd_i.modify && (op_q != bam_pkg::OP_READ);
  assign wr_addr = AW'(q_q);

  // search on the word under evaluation, bits past the size count as used
  always_comb begin
    int lo;
    fw = '0;
    hit = '0;
    lo = 0;
    for (int j = 0; j < WORD_BITS; j++) begin
      fw[j] = word[j] | ((base_q + XW'(j)) >= size);
    end
    for (int j = 0; j < WORD_BITS; j++) begin
      lo = j + 1 - int'(len_q);
      if (lo >= 0) begin
        hit[j] = ~|(fw & (ONES >> (WORD_BITS - (j + 1))) & ~(ONES >> (WORD_BITS - lo)));
      end else begin
        hit[j] = ~|(fw & (ONES >> (WORD_BITS - (j + 1)))) &&
                 ((int'(carry_q) + j + 1) >= int'(len_q));
      end
    end
  end

  always_comb begin
    pick = '0;
    for (int j = WORD_BITS - 1; j >= 0; j--) begin
      if (hit[j]) begin
        pick = OW'(j);
      end
    end
  end

  always_comb begin
    hi = '0;
    for (int j = 0; j < WORD_BITS; j++) begin
      if (fw[j]) begin
        hi = OW'(j);
      end
    end
  end

  always_comb begin
    if (|fw) begin
      carry_d = bam_pkg::LEN_W'(WORD_BITS - 1 - int'(hi));
    end else if ((int'(carry_q) + WORD_BITS) > bam_pkg::MAX_RUN) begin
      carry_d = bam_pkg::LEN_W'(bam_pkg::MAX_RUN);
    end else begin
      carry_d = bam_pkg::LEN_W'(int'(carry_q) + WORD_BITS);
    end
  end

  assign any_hit  = |hit;
  assign last     = (base_q + XW'(WORD_BITS)) >= size;
  assign pos_full = base_q + XW'(pick) + XW'(1) - XW'(len_q);

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bits_in_use_q <= bam_pkg::CFG_W'(CFG_RST);
      vld_q         <= '0;
      rd_cnt_q      <= '0;
      eval_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        bits_in_use_q <= cfg_data_i;
      end
      if (wr_en) begin
        vld_q[wr_addr] <= 1'b1;
      end
      if (cmd_i.start) begin
        rd_cnt_q     <= '0;
        eval_valid_q <= 1'b0;
      end else if (cmd_i.scan) begin
        eval_valid_q <= rd_go;
        if (rd_go) begin
          rd_cnt_q <= rd_cnt_q + CW'(1);
        end
      end else begin
        eval_valid_q <= 1'b0;
      end
    end
  end

  // memory
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= new_word;
    end
    if (rd_en) begin
      rd_word_q <= mem[rd_addr];
      rd_vld_q  <= vld_q[rd_addr];
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      op_q  <= in_data_i.operation;
      idx_q <= in_data_i.bit_index;
      len_q <= (in_data_i.operation == bam_pkg::OP_FIND_CLEAR) ? bam_pkg::LEN_W'(1)
                                                               : in_data_i.run_length;
      base_q  <= '0;
      carry_q <= '0;
      res_q   <= '{status: bam_pkg::STS_RANGE, bit_value: 1'b0, position: '0};
    end
    if (cmd_i.rd_bit) begin
      q_q <= q_calc;
    end
    if (cmd_i.modify) begin
      res_q <= '{status: bam_pkg::STS_OK,
                 bit_value: (op_q == bam_pkg::OP_READ) ? word[off] : 1'b0,
                 position: '0};
    end
    if (cmd_i.scan && eval_valid_q) begin
      base_q  <= base_q + XW'(WORD_BITS);
      carry_q <= carry_d;
      if (any_hit) begin
        res_q <= '{status: bam_pkg::STS_OK, bit_value: 1'b0,
                   position: pos_full[bam_pkg::IDX_W-1:0]};
      end else if (last) begin
        res_q <= '{status: bam_pkg::STS_NONE, bit_value: 1'b0, position: '0};
      end
    end
    if (cmd_i.out_load) begin
      out_q <= res_q;
    end
  end

  assign out_data_o = out_q;

endmodule

### tb/sv/bitmap_allocation_map_tb.sv
// bitmap_allocation_map_tb: self-checking bench for the first-fit bit map allocator
// drives requests and size writes, predicts every result beat and compares it field by field
// depends on bam_pkg and bitmap_allocation_map
`timescale 1ns / 100ps

module bitmap_allocation_map_tb;
  import bam_pkg::*;

  localparam logic [OP_W-1:0] OP_RSVD_FIRST = 3'd5;
  localparam logic [OP_W-1:0] OP_RSVD_LAST  = 3'd7;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int DRAIN_CYCLES = 40;
  localparam int HOLD_CYCLES  = 300;
  localparam int PHASE_ITEMS  = 140;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 cfg_we_i    = 1'b0;
  logic [CFG_W-1:0]     cfg_data_i  = '0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_stall_o;
  in_t                  in_data_i   = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  out_t                 out_data_o;

  logic [MAP_BITS_DEF-1:0] alloc_map    = '0;
  logic [CFG_W-1:0]        managed_bits = CFG_W'(MAP_BITS_DEF);
  out_t                    pending_results[$];
  out_t                    want;
  int                      mismatches   = 0;
  int                      cycle_count  = 0;
  bit                      quiet_mode   = 1'b0;
  bit                      hold_off_req = 1'b0;

  bitmap_allocation_map u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("CHECK FAILED");
    $finish;
  end

  function automatic int unsigned size_limit();
    return (managed_bits > MAP_BITS_DEF) ? MAP_BITS_DEF : int'(managed_bits);
  endfunction

  function automatic out_t predict_result(in_t item);
    out_t        r;
    int unsigned lim;
    int unsigned run;
    bit          found;
    r        = '0;
    r.status = STS_RANGE;
    lim      = size_limit();
    run      = 0;
    found    = 1'b0;
    case (item.operation)
      OP_SET, OP_CLEAR, OP_READ: begin
        if (item.bit_index < lim) begin
          r.status = STS_OK;
          if (item.operation == OP_SET) begin
            alloc_map[item.bit_index] = 1'b1;
          end else if (item.operation == OP_CLEAR) begin
            alloc_map[item.bit_index] = 1'b0;
          end else begin
            r.bit_value = alloc_map[item.bit_index];
          end
        end
      end
      OP_FIND_CLEAR: begin
        r.status = STS_NONE;
        for (int i = 0; i < lim && !found; i++) begin
          if (!alloc_map[i]) begin
            r.status   = STS_OK;
            r.position = IDX_W'(i);
            found      = 1'b1;
          end
        end
      end
      OP_FIND_RUN: begin
        if (item.run_length >= 1 && item.run_length <= MAX_RUN) begin
          r.status = STS_NONE;
          for (int i = 0; i < lim && !found; i++) begin
            run = alloc_map[i] ? 0 : run + 1;
            if (run >= item.run_length) begin
              r.status   = STS_OK;
              r.position = IDX_W'(i + 1 - item.run_length);
              found      = 1'b1;
            end
          end
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  function automatic in_t make_item(logic [OP_W-1:0] op, int unsigned idx, int unsigned len);
    in_t it;
    it.operation  = op;
    it.bit_index  = IDX_W'(idx);
    it.run_length = LEN_W'(len);
    return it;
  endfunction

  function automatic int unsigned pause_len();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 70) return $urandom_range(1, 3);
    if (p < 94) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic in_t random_request(int unsigned lim);
    in_t         it;
    int unsigned pick;
    it = make_item(OP_SET, $urandom_range(0, MAP_BITS_DEF - 1),
                   $urandom_range(0, 1) ? $urandom_range(1, 8) : $urandom_range(1, MAX_RUN));
    if (lim > 0 && $urandom_range(0, 9) != 0) begin
      it.bit_index = IDX_W'($urandom_range(0, lim - 1));
    end
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      it.operation = OP_SET;
    end else if (pick < 50) begin
      it.operation = OP_CLEAR;
    end else if (pick < 62) begin
      it.operation = OP_READ;
    end else if (pick < 72) begin
      it.operation = OP_FIND_CLEAR;
    end else if (pick < 92) begin
      it.operation = OP_FIND_RUN;
    end else if (pick < 96) begin
      it.operation  = OP_FIND_RUN;
      it.run_length = LEN_W'($urandom_range(0, (1 << LEN_W) - 1));
    end else begin
      it.operation = OP_W'($urandom_range(OP_RSVD_FIRST, OP_RSVD_LAST));
    end
    return it;
  endfunction

  // receiver side: random stalls, plus one long hold-off on request
  initial begin
    bit          stall_val;
    int unsigned stall_len;
    forever begin
      if (hold_off_req) begin
        stall_val    = 1'b1;
        stall_len    = HOLD_CYCLES;
        hold_off_req = 1'b0;
      end else if (quiet_mode || $urandom_range(0, 99) < 65) begin
        stall_val = 1'b0;
        stall_len = $urandom_range(1, 10);
      end else begin
        stall_val = 1'b1;
        stall_len = pause_len();
      end
      @(negedge clk_i);
      out_stall_i <= stall_val;
      repeat (stall_len - 1) @(negedge clk_i);
    end
  end

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result beat with nothing expected, actual %p", $time, out_data_o);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (out_data_o.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, out_data_o.status);
          mismatches++;
        end
        if (out_data_o.bit_value !== want.bit_value) begin
          $display("%0t: bit_value expected %0d actual %0d", $time, want.bit_value,
                   out_data_o.bit_value);
          mismatches++;
        end
        if (out_data_o.position !== want.position) begin
          $display("%0t: position expected %0d actual %0d", $time, want.position,
                   out_data_o.position);
          mismatches++;
        end
      end
    end
  end

  task automatic send_request(in_t item);
    int unsigned gap;
    gap = quiet_mode ? 0 : ($urandom_range(0, 1) ? 0 : pause_len());
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (in_stall_o);
    pending_results.push_back(predict_result(item));
  endtask

  task automatic stop_input();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  task automatic write_size(int unsigned value);
    stop_input();
    while (pending_results.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= CFG_W'(value);
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    managed_bits = CFG_W'(value);
  endtask

  task automatic test_reset_state();
    send_request(make_item(OP_FIND_CLEAR, 0, 1));
    send_request(make_item(OP_FIND_RUN, 0, MAX_RUN));
    send_request(make_item(OP_SET, 0, 1));
    send_request(make_item(OP_SET, MAP_BITS_DEF - 1, 1));
    send_request(make_item(OP_READ, MAP_BITS_DEF - 1, 1));
    send_request(make_item(OP_READ, 5, 1));
    send_request(make_item(OP_FIND_CLEAR, 0, 1));
    send_request(make_item(OP_FIND_RUN, 0, 1));
    send_request(make_item(OP_CLEAR, 0, 1));
    send_request(make_item(OP_READ, 0, 1));
    send_request(make_item(OP_FIND_RUN, 0, 0));
    send_request(make_item(OP_FIND_RUN, 0, MAX_RUN + 1));
    for (int op = OP_RSVD_FIRST; op <= OP_RSVD_LAST; op++) begin
      send_request(make_item(OP_W'(op), 3, 2));
    end
  endtask

  task automatic test_size_edges();
    // nothing managed
    write_size(0);
    send_request(make_item(OP_SET, 0, 1));
    send_request(make_item(OP_FIND_CLEAR, 0, 1));
    send_request(make_item(OP_FIND_RUN, 0, 1));
    // single bit: index past the end, then a full map
    write_size(1);
    send_request(make_item(OP_SET, 1, 1));
    send_request(make_item(OP_SET, 0, 1));
    send_request(make_item(OP_FIND_CLEAR, 0, 1));
    send_request(make_item(OP_CLEAR, 0, 1));
    // run that ends on the last managed bit
    write_size(64);
    send_request(make_item(OP_FIND_RUN, 0, MAX_RUN));
    // size above the map
    write_size((1 << CFG_W) - 1);
    send_request(make_item(OP_READ, MAP_BITS_DEF - 1, 1));
  endtask

  task automatic test_back_to_back();
    quiet_mode = 1'b1;
    for (int n = 0; n < 60; n++) begin
      send_request(random_request(size_limit()));
    end
    quiet_mode = 1'b0;
  endtask

  task automatic test_input_pressure();
    quiet_mode   = 1'b1;
    hold_off_req = 1'b1;
    for (int n = 0; n < 40; n++) begin
      send_request(random_request(size_limit()));
    end
    quiet_mode = 1'b0;
  endtask

  task automatic test_random_traffic();
    int unsigned lim;
    int unsigned start;
    int unsigned count;
    int unsigned pick;
    int unsigned sent;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: write_size(MAP_BITS_DEF);
        1: write_size($urandom_range(2, MAP_BITS_DEF - 1));
        2: write_size(1);
        3: write_size($urandom_range(MAP_BITS_DEF + 1, (1 << CFG_W) - 1));
        4: write_size(64);
        default: write_size(MAP_BITS_DEF);
      endcase
      lim  = size_limit();
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        pick = $urandom_range(0, 99);
        if (pick < 20 && lim > 1) begin
          // allocate or free a block, then search for a run
          start = $urandom_range(0, lim - 1);
          count = $urandom_range(2, 40);
          for (int k = 0; k < count && start + k < lim; k++) begin
            send_request(make_item(pick < 12 ? OP_SET : OP_CLEAR, start + k, 1));
            sent++;
          end
          send_request(make_item(OP_FIND_RUN, 0, $urandom_range(1, pick < 12 ? 16 : MAX_RUN)));
          sent++;
        end else begin
          send_request(random_request(lim));
          sent++;
        end
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_reset_state();
    test_size_edges();
    test_back_to_back();
    test_input_pressure();
    test_random_traffic();
    stop_input();
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### bitmap_allocation_map.f
hw/rtl/bam_pkg.sv
hw/rtl/bam_ctrl.sv
hw/rtl/bam_datapath.sv
hw/rtl/bitmap_allocation_map.sv
tb/sv/bitmap_allocation_map_tb.sv
